>>> hw/rtl/jets_pkg.sv
// ----------------------------------------------------------------------------
// jets_pkg: shared types, constants and helpers for the Julia pixel block
// Item payloads, register map, ring token layout, palette and saturation.
// ----------------------------------------------------------------------------
package jets_pkg;

  // Field widths fixed by the item format
  localparam int ITER_W  = 12;
  localparam int COORD_W = 12;
  localparam int COLOR_W = 24;
  localparam int PAL_LEN = 15;
  // Palette position counter, wide enough for the largest palette size
  localparam int PIDX_W  = 6;
  // Iteration cells in the ring
  localparam int NUM_CELLS = 2;

  // Register indexes (word address paddr[4:2])
  localparam logic [2:0] RegXOrigin = 3'd0;
  localparam logic [2:0] RegXStep   = 3'd1;
  localparam logic [2:0] RegYOrigin = 3'd2;
  localparam logic [2:0] RegYStep   = 3'd3;
  localparam logic [2:0] RegCReal   = 3'd4;
  localparam logic [2:0] RegCImag   = 3'd5;
  localparam logic [2:0] RegMaxIter = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_RUN
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } pix_in_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iterations;
    logic               draw;
    logic [COLOR_W-1:0] color;
  } pix_out_t;

  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] x_step;
    logic signed [31:0] y_origin;
    logic signed [31:0] y_step;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic [ITER_W-1:0]  max_iter;
  } cfg_t;

  // Settings every cell sees
  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic [ITER_W-1:0]  limit;
  } iter_cfg_t;

  // One pixel in flight around the ring
  typedef struct packed {
    logic               valid;
    logic               done;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [ITER_W-1:0]  count;
    logic [PIDX_W-1:0]  pidx;
  } tok_t;

  localparam logic [COLOR_W-1:0] PALETTE [PAL_LEN] = '{
    24'd4333071, 24'd1640218, 24'd590127,  24'd1892,     24'd263241,
    24'd797834,  24'd1594033, 24'd3767761, 24'd8828389,  24'd13888760,
    24'd16304479, 24'd16755200, 24'd13402112, 24'd10049280, 24'd6960131
  };

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Fold a palette position below 64 into the 15-entry table
  function automatic logic [3:0] pal_index(input logic [PIDX_W-1:0] p);
    logic [PIDX_W-1:0] v;
    v = p;
    for (int k = 0; k < 4; k++) begin
      if (v >= PIDX_W'(PAL_LEN)) begin
        v = v - PIDX_W'(PAL_LEN);
      end
    end
    return v[3:0];
  endfunction

endpackage

>>> hw/rtl/jets_cell.sv
// ----------------------------------------------------------------------------
// jets_cell: one z = z^2 + c iteration cell
// Stage one registers the three products, stage two shifts, adds, saturates,
// runs the escape test and hands the token to the next cell.
// ----------------------------------------------------------------------------
module jets_cell #(
  parameter int FRAC_BITS    = 26,
  parameter int PALETTE_SIZE = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jets_pkg::iter_cfg_t cfg_i,
  input  jets_pkg::tok_t      tok_i,
  output jets_pkg::tok_t      tok_o
);

  localparam int PidxW = jets_pkg::PIDX_W;
  localparam int IterW = jets_pkg::ITER_W;
  localparam logic signed [63:0] EscapeLim = 64'sd4 <<< FRAC_BITS;
  localparam logic [PidxW-1:0]   PalLast   = PidxW'(PALETTE_SIZE - 1);

  logic                    in_act;
  logic signed [63:0]      rr_d, ii_d, ri_d;
  logic                    s1_vld_q;
  logic signed [63:0]      s1_rr_q, s1_ii_q, s1_ri_q;
  logic [IterW-1:0]        s1_count_q;
  logic [PidxW-1:0]        s1_pidx_q;
  logic signed [63:0]      rr, ii, ri2;
  logic                    esc;
  logic [IterW-1:0]        cnt_inc;
  logic [PidxW-1:0]        pidx_inc;
  jets_pkg::tok_t          nxt;
  logic                    out_vld_q;
  jets_pkg::tok_t          out_q;

  // A finished token is dropped here
  assign in_act = tok_i.valid & ~tok_i.done;

  // Stage one: full products
  assign rr_d = 64'(tok_i.re) * 64'(tok_i.re);
  assign ii_d = 64'(tok_i.im) * 64'(tok_i.im);
  assign ri_d = 64'(tok_i.re) * 64'(tok_i.im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_act) begin
      s1_rr_q    <= rr_d;
      s1_ii_q    <= ii_d;
      s1_ri_q    <= ri_d;
      s1_count_q <= tok_i.count;
      s1_pidx_q  <= tok_i.pidx;
    end
  end

  // Stage two: rescale, update, escape test
  always_comb begin
    rr       = s1_rr_q >>> FRAC_BITS;
    ii       = s1_ii_q >>> FRAC_BITS;
    ri2      = s1_ri_q >>> (FRAC_BITS - 1);
    esc      = (rr + ii) > EscapeLim;
    cnt_inc  = s1_count_q + IterW'(1);
    pidx_inc = (s1_pidx_q == PalLast) ? '0 : s1_pidx_q + PidxW'(1);
    nxt.valid = s1_vld_q;
    nxt.done  = esc || (cnt_inc == cfg_i.limit);
    nxt.re    = jets_pkg::sat32(rr - ii + 64'(cfg_i.c_real));
    nxt.im    = jets_pkg::sat32(ri2 + 64'(cfg_i.c_imag));
    nxt.count = esc ? s1_count_q : cnt_inc;
    nxt.pidx  = esc ? s1_pidx_q : pidx_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      out_q <= nxt;
    end
  end

  always_comb begin
    tok_o       = out_q;
    tok_o.valid = out_vld_q;
  end

endmodule

>>> hw/rtl/julia_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel: Julia set escape-time evaluator for one pixel
// Maps (column, row) to a start point, iterates z = z^2 + c and returns the
// count, a draw flag and a palette color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes a column and row.
//   Output channel (out_valid_o/out_ready_i/out_data_o) gives one result
//   item per input item, in order.
//   The APB port sets the window origin, step, the constant c and the limit;
//   write it only while no pixel is in progress.
// Flow:
//   The next item is taken only after the last one has left the ring and
//   the pending slot; a zero limit runs no iteration. Each iteration
//   passes through two registers of a ring of iteration cells: the product
//   stage and the update stage. One pixel is in the ring at a time.
// Reset: registers return to their default window and limit, the ring and
//   both result slots empty.
// Stall: a held result sits in the output register; one more pixel may run
//   to completion into a pending slot, then the input stops taking items.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel #(
  parameter int COORD_BITS   = 12,
  parameter int FRAC_BITS    = 26,
  parameter int ITER_BITS    = 12,
  parameter int PALETTE_SIZE = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jets_pkg::pix_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jets_pkg::pix_out_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IterW     = jets_pkg::ITER_W;
  localparam int CoordW    = jets_pkg::COORD_W;
  localparam int NumCells  = jets_pkg::NUM_CELLS;
  localparam int CoordKeep = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam logic [CoordW-1:0] ColMask = CoordW'((1 << CoordKeep) - 1);
  localparam int IterMax   = (1 << ITER_BITS) - 1;

  jets_pkg::cfg_t      cfg_q;
  jets_pkg::iter_cfg_t icfg;
  logic [IterW-1:0]    limit;
  logic [2:0]          reg_idx;
  logic                cfg_wr;

  jets_pkg::state_e    state_q, state_d;
  logic                accept, inject, pend_set;

  logic [CoordW-1:0]   col_m, row_m;
  logic signed [44:0]  col_prod_q, row_prod_q;
  jets_pkg::tok_t      start_tok;

  jets_pkg::tok_t      tok_in  [NumCells];
  jets_pkg::tok_t      tok_out [NumCells];
  logic [NumCells-1:0] ring_vld;
  logic                fin_vld;
  jets_pkg::tok_t      fin_tok;

  logic [IterW-1:0]    res_count;
  logic [jets_pkg::PIDX_W-1:0] res_pidx;
  jets_pkg::pix_out_t  res;

  logic                pend_vld_q, pend_vld_d;
  jets_pkg::pix_out_t  pend_q;
  logic                out_vld_q, out_vld_d;
  jets_pkg::pix_out_t  out_q;
  logic                move;

  // ------------------------------------------------------------------
  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin <= -32'sd134217728;
      cfg_q.x_step   <= 32'sd206918;
      cfg_q.y_origin <= -32'sd80530637;
      cfg_q.y_step   <= 32'sd178957;
      cfg_q.c_real   <= -32'sd47094316;
      cfg_q.c_imag   <= -32'sd25783226;
      cfg_q.max_iter <= IterW'(100);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        jets_pkg::RegXOrigin: cfg_q.x_origin <= pwdata;
        jets_pkg::RegXStep:   cfg_q.x_step   <= pwdata;
        jets_pkg::RegYOrigin: cfg_q.y_origin <= pwdata;
        jets_pkg::RegYStep:   cfg_q.y_step   <= pwdata;
        jets_pkg::RegCReal:   cfg_q.c_real   <= pwdata;
        jets_pkg::RegCImag:   cfg_q.c_imag   <= pwdata;
        jets_pkg::RegMaxIter: cfg_q.max_iter <= pwdata[IterW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      jets_pkg::RegXOrigin: prdata = cfg_q.x_origin;
      jets_pkg::RegXStep:   prdata = cfg_q.x_step;
      jets_pkg::RegYOrigin: prdata = cfg_q.y_origin;
      jets_pkg::RegYStep:   prdata = cfg_q.y_step;
      jets_pkg::RegCReal:   prdata = cfg_q.c_real;
      jets_pkg::RegCImag:   prdata = cfg_q.c_imag;
      jets_pkg::RegMaxIter: prdata = {{(32 - IterW){1'b0}}, cfg_q.max_iter};
      default:              prdata = '0;
    endcase
  end

  // Limit capped to the counter range
  assign limit = (int'(cfg_q.max_iter) > IterMax) ? IterW'(IterMax) : cfg_q.max_iter;

  assign icfg.c_real = cfg_q.c_real;
  assign icfg.c_imag = cfg_q.c_imag;
  assign icfg.limit  = limit;

  // ------------------------------------------------------------------
  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jets_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jets_pkg::S_IDLE: begin
        if (accept) state_d = jets_pkg::S_START;
      end
      jets_pkg::S_START: begin
        state_d = (limit == '0) ? jets_pkg::S_IDLE : jets_pkg::S_RUN;
      end
      jets_pkg::S_RUN: begin
        if (fin_vld) state_d = jets_pkg::S_IDLE;
      end
      default: state_d = jets_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == jets_pkg::S_IDLE) && !pend_vld_q;
    inject     = (state_q == jets_pkg::S_START) && (limit != '0);
    pend_set   = ((state_q == jets_pkg::S_START) && (limit == '0)) ||
                 ((state_q == jets_pkg::S_RUN) && fin_vld);
  end

  assign accept = in_valid_i & in_ready_o;

  // ------------------------------------------------------------------
  // Start point: products on accept, sum and clamp in the next cycle
  assign col_m = in_data_i.column & ColMask;
  assign row_m = in_data_i.row & ColMask;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_prod_q <= $signed({1'b0, col_m}) * cfg_q.x_step;
      row_prod_q <= $signed({1'b0, row_m}) * cfg_q.y_step;
    end
  end

  always_comb begin
    start_tok.valid = inject;
    start_tok.done  = 1'b0;
    start_tok.re    = jets_pkg::sat32(64'(cfg_q.x_origin) + 64'(col_prod_q));
    start_tok.im    = jets_pkg::sat32(64'(cfg_q.y_origin) + 64'(row_prod_q));
    start_tok.count = '0;
    start_tok.pidx  = '0;
  end

  // ------------------------------------------------------------------
  // Ring of iteration cells
  always_comb begin
    tok_in[0] = tok_out[NumCells-1];
    if (inject) begin
      tok_in[0] = start_tok;
    end
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign tok_in[g] = tok_out[g-1];
    end
    jets_cell #(
      .FRAC_BITS    (FRAC_BITS),
      .PALETTE_SIZE (PALETTE_SIZE)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (icfg),
      .tok_i  (tok_in[g]),
      .tok_o  (tok_out[g])
    );
    assign ring_vld[g] = tok_out[g].valid;
  end

  // Pick up a finished token from whichever cell holds it
  always_comb begin
    fin_vld = 1'b0;
    fin_tok = tok_out[0];
    for (int k = 0; k < NumCells; k++) begin
      if (tok_out[k].valid && tok_out[k].done) begin
        fin_vld = 1'b1;
        fin_tok = tok_out[k];
      end
    end
  end

  // ------------------------------------------------------------------
  // Result formatting
  always_comb begin
    res_count      = (state_q == jets_pkg::S_START) ? '0 : fin_tok.count;
    res_pidx       = (state_q == jets_pkg::S_START) ? '0 : fin_tok.pidx;
    res.iterations = res_count;
    res.draw       = (res_count != '0) && (res_count < limit);
    res.color      = res.draw ? jets_pkg::PALETTE[jets_pkg::pal_index(res_pidx)] : '0;
  end

  // Pending slot feeds the output register
  always_comb begin
    move       = pend_vld_q && (!out_vld_q || out_ready_i);
    pend_vld_d = pend_set ? 1'b1 : (move ? 1'b0 : pend_vld_q);
    out_vld_d  = move ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_set) pend_q <= res;
    if (move)     out_q  <= pend_q;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // Never more than one pixel in the ring
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(ring_vld) <= 1)
    else $error("more than one token in the iteration ring");

  // Ring is empty whenever the sequencer is idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jets_pkg::S_IDLE) |-> (ring_vld == '0))
    else $error("token left in ring while idle");

  // A drawn pixel has run at least one iteration
  a_draw_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.draw) |-> (out_data_o.iterations != '0))
    else $error("draw set with zero iterations");

  // An undrawn pixel is black
  a_nodraw_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.draw) |-> (out_data_o.color == '0))
    else $error("color set on undrawn pixel");

  // Injection always starts a run
  a_inject_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inject |=> (state_q == jets_pkg::S_RUN))
    else $error("injected token without entering run");
`endif

endmodule
